FILE: rtl/recursive_lock_wait_queue_defines.svh
// Assertion macros for the lock wait queue.
// Both forms sample on the rising edge of clk and are disabled while rst_n is low.
// Define NO_ASSERTIONS to compile them out.
`ifndef RECURSIVE_LOCK_WAIT_QUEUE_DEFINES_SVH
`define RECURSIVE_LOCK_WAIT_QUEUE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Consequent checked in the same cycle as the antecedent
`define RLWQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent checked in the cycle after the antecedent
`define RLWQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RLWQ_ASSERT_SAME(label, ante, cons, msg)
`define RLWQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/rlwq_pkg.sv
// ----------------------------------------------------------------------------
// rlwq_pkg
// Shared types and constants for the recursive lock with a FIFO wait queue.
// ----------------------------------------------------------------------------
`default_nettype none

package rlwq_pkg;

  // Field widths of the request and result words
  localparam int THREAD_ID_W = 6;
  localparam int ID_SPACE    = 1 << THREAD_ID_W;
  localparam int STATUS_W    = 4;
  localparam int WCOUNT_W    = 7;

  // Request types
  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_GRANTED         = 4'd0;
  localparam logic [STATUS_W-1:0] STATUS_QUEUED          = 4'd1;
  localparam logic [STATUS_W-1:0] STATUS_NESTED_ACQ      = 4'd2;
  localparam logic [STATUS_W-1:0] STATUS_FREED           = 4'd3;
  localparam logic [STATUS_W-1:0] STATUS_HANDOFF         = 4'd4;
  localparam logic [STATUS_W-1:0] STATUS_NESTED_REL      = 4'd5;
  localparam logic [STATUS_W-1:0] STATUS_ALREADY_WAITING = 4'd6;
  localparam logic [STATUS_W-1:0] STATUS_NOT_HELD        = 4'd7;
  localparam logic [STATUS_W-1:0] STATUS_SATURATED       = 4'd8;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the incoming request word
    logic exec;   // resolve the request and load the result register
  } rlwq_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // result register empty or being taken this cycle
  } rlwq_sts_t;

endpackage : rlwq_pkg

`default_nettype wire

FILE: rtl/rlwq_if.sv
// ----------------------------------------------------------------------------
// rlwq_if
// Valid/ready channels for the request word and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlwq_in_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [rlwq_pkg::THREAD_ID_W-1:0] thread_id;

  modport source (output valid, output req_type, output thread_id, input ready);
  modport sink   (input valid, input req_type, input thread_id, output ready);
endinterface : rlwq_in_if

interface rlwq_out_if;
  logic                             valid;
  logic                             ready;
  logic [rlwq_pkg::STATUS_W-1:0]    status;
  logic [rlwq_pkg::THREAD_ID_W-1:0] new_holder;
  logic                             held;
  logic [rlwq_pkg::WCOUNT_W-1:0]    waiting_count;

  modport source (output valid, output status, output new_holder, output held,
                  output waiting_count, input ready);
  modport sink   (input valid, input status, input new_holder, input held,
                  input waiting_count, output ready);
endinterface : rlwq_out_if

`default_nettype wire

FILE: rtl/rlwq_ram.sv
// ----------------------------------------------------------------------------
// rlwq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rlwq_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule : rlwq_ram

`default_nettype wire

FILE: rtl/rlwq_ctrl.sv
// ----------------------------------------------------------------------------
// rlwq_ctrl
// Request sequencer: capture a request word, then resolve it once the
// result register can take the answer.
// ----------------------------------------------------------------------------
`default_nettype none

module rlwq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rlwq_pkg::rlwq_sts_t sts,
  output rlwq_pkg::rlwq_cmd_t      cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  // Take a word only when no request is in flight
  assign in_ready = (state_r == S_IDLE);
  assign cmd.load = in_valid && in_ready;
  assign cmd.exec = (state_r == S_EXEC) && sts.out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.exec) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule : rlwq_ctrl

`default_nettype wire

FILE: rtl/rlwq_dp.sv
// ----------------------------------------------------------------------------
// rlwq_dp
// Lock state, nesting count, wait queue pointers and waiting bitmap, the
// wait queue memory and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rlwq_dp #(
  parameter int THREAD_COUNT = 64,
  parameter int MAX_NEST     = 255
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire rlwq_pkg::rlwq_cmd_t                 cmd,
  output rlwq_pkg::rlwq_sts_t                      sts,
  input  wire logic                                in_req_type,
  input  wire logic [rlwq_pkg::THREAD_ID_W-1:0]    in_thread_id,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [rlwq_pkg::STATUS_W-1:0]       out_status,
  output logic      [rlwq_pkg::THREAD_ID_W-1:0]    out_new_holder,
  output logic                                     out_held,
  output logic      [rlwq_pkg::WCOUNT_W-1:0]       out_waiting_count
);

  localparam int PTR_W  = $clog2(THREAD_COUNT);
  localparam int CNT_W  = $clog2(THREAD_COUNT + 1);
  localparam int NEST_W = $clog2(MAX_NEST + 1);
  localparam int ID_W   = rlwq_pkg::THREAD_ID_W;

  localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(THREAD_COUNT - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(THREAD_COUNT);
  localparam logic [NEST_W-1:0] NEST_MAX  = NEST_W'(MAX_NEST);

  // Captured request word
  logic            req_type_r;
  logic [ID_W-1:0] tid_r;

  // Lock and queue state
  logic                          held_r,   held_nxt;
  logic [ID_W-1:0]               holder_r, holder_nxt;
  logic [NEST_W-1:0]             nest_r,   nest_nxt;
  logic [PTR_W-1:0]              head_r,   head_nxt;
  logic [PTR_W-1:0]              tail_r,   tail_nxt;
  logic [CNT_W-1:0]              count_r,  count_nxt;
  logic [rlwq_pkg::ID_SPACE-1:0] map_r,    map_nxt;

  // Result register
  logic                            out_valid_r, out_valid_nxt;
  logic [rlwq_pkg::STATUS_W-1:0]   status_r,    status_nxt;
  logic [ID_W-1:0]                 res_holder_r;
  logic                            res_held_r;
  logic [rlwq_pkg::WCOUNT_W-1:0]   res_count_r;

  // Wait queue memory
  logic            push;
  logic [ID_W-1:0] head_id;

  // Head entry is read continuously through the registered read port
  rlwq_ram #(
    .WIDTH (ID_W),
    .DEPTH (THREAD_COUNT)
  ) u_wait_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (tail_r),
    .wr_data (tid_r),
    .rd_addr (head_r),
    .rd_data (head_id)
  );

  assign sts.out_free = !out_valid_r || out_ready;

  // Resolve the captured request
  always_comb begin
    held_nxt   = held_r;
    holder_nxt = holder_r;
    nest_nxt   = nest_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    map_nxt    = map_r;
    push       = 1'b0;
    status_nxt = rlwq_pkg::STATUS_NOT_HELD;
    if (req_type_r == rlwq_pkg::REQ_ACQUIRE) begin
      if (!held_r) begin
        held_nxt   = 1'b1;
        holder_nxt = tid_r;
        nest_nxt   = '0;
        status_nxt = rlwq_pkg::STATUS_GRANTED;
      end else if (holder_r == tid_r) begin
        if (nest_r >= NEST_MAX) begin
          status_nxt = rlwq_pkg::STATUS_SATURATED;
        end else begin
          nest_nxt   = nest_r + 1'b1;
          status_nxt = rlwq_pkg::STATUS_NESTED_ACQ;
        end
      end else if (map_r[tid_r] || (count_r >= FULL_CNT)) begin
        status_nxt = rlwq_pkg::STATUS_ALREADY_WAITING;
      end else begin
        push           = cmd.exec;
        tail_nxt       = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
        count_nxt      = count_r + 1'b1;
        map_nxt[tid_r] = 1'b1;
        status_nxt     = rlwq_pkg::STATUS_QUEUED;
      end
    end else begin
      if (!held_r) begin
        status_nxt = rlwq_pkg::STATUS_NOT_HELD;
      end else if (nest_r != '0) begin
        nest_nxt   = nest_r - 1'b1;
        status_nxt = rlwq_pkg::STATUS_NESTED_REL;
      end else if (count_r == '0) begin
        held_nxt   = 1'b0;
        holder_nxt = '0;
        status_nxt = rlwq_pkg::STATUS_FREED;
      end else begin
        head_nxt         = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
        count_nxt        = count_r - 1'b1;
        map_nxt[head_id] = 1'b0;
        holder_nxt       = head_id;
        nest_nxt         = '0;
        status_nxt       = rlwq_pkg::STATUS_HANDOFF;
      end
    end
  end

  // Hold the result until taken, set it on resolve
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and lock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 1'b0;
      holder_r    <= '0;
      nest_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      map_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.exec) begin
        held_r   <= held_nxt;
        holder_r <= holder_nxt;
        nest_r   <= nest_nxt;
        head_r   <= head_nxt;
        tail_r   <= tail_nxt;
        count_r  <= count_nxt;
        map_r    <= map_nxt;
      end
    end
  end

  // Request word and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= in_req_type;
      tid_r      <= in_thread_id;
    end
    if (cmd.exec) begin
      status_r     <= status_nxt;
      res_holder_r <= held_nxt ? holder_nxt : '0;
      res_held_r   <= held_nxt;
      res_count_r  <= rlwq_pkg::WCOUNT_W'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_new_holder    = res_holder_r;
  assign out_held          = res_held_r;
  assign out_waiting_count = res_count_r;

endmodule : rlwq_dp

`default_nettype wire

FILE: rtl/recursive_lock_wait_queue.sv
// ----------------------------------------------------------------------------
// recursive_lock_wait_queue
// Recursive mutex with a FIFO of waiting threads and a waiting bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one request word: req_type (acquire or release) and
//          thread_id (ignored on release).
//   out_ch returns one result word per request: status, new_holder, held
//          and waiting_count after the request.
//   A request word is captured into the request register when accepted,
//   resolved once the result register can take the answer, and its result
//   is then held in the result register. in_ch.ready stays low from the
//   capture until the request is resolved, so a new word is not taken
//   before the last one is resolved.
//   Synchronous reset frees the lock, clears the nesting count, the queue
//   pointers, the count and the waiting bitmap. The queue memory itself is
//   not cleared; only entries that were pushed are ever read.
//   If out_ch stalls, the result register holds its word and the pending
//   request waits, with in_ch.ready low, until the register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "recursive_lock_wait_queue_defines.svh"

module recursive_lock_wait_queue #(
  parameter int THREAD_COUNT = 64,
  parameter int MAX_NEST     = 255
) (
  input wire logic    clk,
  input wire logic    rst_n,
  rlwq_in_if.sink     in_ch,
  rlwq_out_if.source  out_ch
);

  rlwq_pkg::rlwq_cmd_t cmd;
  rlwq_pkg::rlwq_sts_t sts;

  // Sequencer
  rlwq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Lock state, wait queue and result register
  rlwq_dp #(
    .THREAD_COUNT (THREAD_COUNT),
    .MAX_NEST     (MAX_NEST)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_ch.req_type),
    .in_thread_id      (in_ch.thread_id),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_new_holder    (out_ch.new_holder),
    .out_held          (out_ch.held),
    .out_waiting_count (out_ch.waiting_count)
  );

  // A captured word blocks further words until it is resolved
  `RLWQ_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "word accepted while busy")

  // A free lock reports no holder
  `RLWQ_ASSERT_SAME(a_free_no_holder, out_ch.valid && !out_ch.held, out_ch.new_holder == '0, "free lock with holder")

  // Queueing only happens behind a holder
  `RLWQ_ASSERT_SAME(a_queued_held, out_ch.valid && (out_ch.status == rlwq_pkg::STATUS_QUEUED), out_ch.held && (out_ch.waiting_count != '0), "queued without holder")

  // Freeing leaves an empty queue and no holder
  `RLWQ_ASSERT_SAME(a_freed_empty, out_ch.valid && (out_ch.status == rlwq_pkg::STATUS_FREED), !out_ch.held && (out_ch.waiting_count == '0), "freed with waiters")

endmodule : recursive_lock_wait_queue

`default_nettype wire

FILE: tb/recursive_lock_wait_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recursive_lock_wait_queue_test
// Self-checking bench for the recursive lock. A directed table covers reset
// behaviour, nesting up to saturation, queueing, hand-off and the error
// codes. A state-aware random phase then drives fill, drain, deep-nesting and
// noise sequences. A local lock model predicts every result word, and a
// monitor checks each result against the oldest prediction. Both channels
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module recursive_lock_wait_queue_test;

  localparam int MAX_DEPTH    = 255;
  localparam int RANDOM_WORDS = 680;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_OFF_LEN = 60;
  localparam int HOLD_OFF_AT  = 700;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic                             req_type;
    logic [rlwq_pkg::THREAD_ID_W-1:0] thread_id;
  } lock_req_t;

  typedef struct packed {
    logic [rlwq_pkg::STATUS_W-1:0]    status;
    logic [rlwq_pkg::THREAD_ID_W-1:0] new_holder;
    logic                             held;
    logic [rlwq_pkg::WCOUNT_W-1:0]    waiting_count;
  } lock_res_t;

  // One line of the directed script; fixed marks a typed expectation
  typedef struct {
    logic                             req_type;
    logic [rlwq_pkg::THREAD_ID_W-1:0] thread_id;
    int                               reps;
    bit                               fixed;
    lock_res_t                        res;
  } script_row_t;

  typedef enum int {
    MODE_MIX,
    MODE_FILL,
    MODE_DRAIN,
    MODE_NEST,
    MODE_NOISE
  } traffic_mode_t;

  localparam int SCRIPT_ROWS = 19;

  script_row_t lock_script [SCRIPT_ROWS] = '{
    '{rlwq_pkg::REQ_RELEASE, 6'd0, 1, 1'b1, '{rlwq_pkg::STATUS_NOT_HELD, 6'd0, 1'b0, 7'd0}},
    '{rlwq_pkg::REQ_RELEASE, 6'd63, 1, 1'b1, '{rlwq_pkg::STATUS_NOT_HELD, 6'd0, 1'b0, 7'd0}},
    '{rlwq_pkg::REQ_ACQUIRE, 6'd63, 1, 1'b1, '{rlwq_pkg::STATUS_GRANTED, 6'd63, 1'b1, 7'd0}},
    '{rlwq_pkg::REQ_ACQUIRE, 6'd63, 255, 1'b0, '0},
    '{rlwq_pkg::REQ_ACQUIRE, 6'd63, 1, 1'b1, '{rlwq_pkg::STATUS_SATURATED, 6'd63, 1'b1, 7'd0}},
    '{rlwq_pkg::REQ_ACQUIRE, 6'd0, 1, 1'b1, '{rlwq_pkg::STATUS_QUEUED, 6'd63, 1'b1, 7'd1}},
    '{rlwq_pkg::REQ_ACQUIRE, 6'd0, 1, 1'b1,
      '{rlwq_pkg::STATUS_ALREADY_WAITING, 6'd63, 1'b1, 7'd1}},
    '{rlwq_pkg::REQ_ACQUIRE, 6'd42, 1, 1'b1, '{rlwq_pkg::STATUS_QUEUED, 6'd63, 1'b1, 7'd2}},
    '{rlwq_pkg::REQ_RELEASE, 6'd21, 1, 1'b1,
      '{rlwq_pkg::STATUS_NESTED_REL, 6'd63, 1'b1, 7'd2}},
    '{rlwq_pkg::REQ_RELEASE, 6'd0, 254, 1'b0, '0},
    '{rlwq_pkg::REQ_RELEASE, 6'd0, 1, 1'b1, '{rlwq_pkg::STATUS_HANDOFF, 6'd0, 1'b1, 7'd1}},
    '{rlwq_pkg::REQ_ACQUIRE, 6'd0, 1, 1'b1, '{rlwq_pkg::STATUS_NESTED_ACQ, 6'd0, 1'b1, 7'd1}},
    '{rlwq_pkg::REQ_ACQUIRE, 6'd63, 1, 1'b1, '{rlwq_pkg::STATUS_QUEUED, 6'd0, 1'b1, 7'd2}},
    '{rlwq_pkg::REQ_RELEASE, 6'd5, 1, 1'b1, '{rlwq_pkg::STATUS_NESTED_REL, 6'd0, 1'b1, 7'd2}},
    '{rlwq_pkg::REQ_RELEASE, 6'd0, 1, 1'b1, '{rlwq_pkg::STATUS_HANDOFF, 6'd42, 1'b1, 7'd1}},
    '{rlwq_pkg::REQ_RELEASE, 6'd0, 1, 1'b1, '{rlwq_pkg::STATUS_HANDOFF, 6'd63, 1'b1, 7'd0}},
    '{rlwq_pkg::REQ_RELEASE, 6'd0, 1, 1'b1, '{rlwq_pkg::STATUS_FREED, 6'd0, 1'b0, 7'd0}},
    '{rlwq_pkg::REQ_ACQUIRE, 6'd0, 1, 1'b1, '{rlwq_pkg::STATUS_GRANTED, 6'd0, 1'b1, 7'd0}},
    '{rlwq_pkg::REQ_RELEASE, 6'd63, 1, 1'b1, '{rlwq_pkg::STATUS_FREED, 6'd0, 1'b0, 7'd0}}
  };

  logic clk;
  logic rst_n;

  rlwq_in_if  in_ch ();
  rlwq_out_if out_ch ();

  recursive_lock_wait_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Lock model state
  logic                             owned;
  logic [rlwq_pkg::THREAD_ID_W-1:0] owner;
  int                               depth;
  logic [rlwq_pkg::THREAD_ID_W-1:0] wait_line [$];
  logic [rlwq_pkg::ID_SPACE-1:0]    queued_map;

  lock_res_t expected_results [$];
  int        mismatches;
  int        results_taken;
  int        cycles;
  int        burst_left;

  // Clock and reset
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Resolve one request against the lock model and advance it
  function automatic lock_res_t resolve_request(lock_req_t rq);
    lock_res_t                        res;
    logic [rlwq_pkg::STATUS_W-1:0]    st;
    logic [rlwq_pkg::THREAD_ID_W-1:0] next;
    if (rq.req_type == rlwq_pkg::REQ_ACQUIRE) begin
      if (!owned) begin
        owned = 1'b1;
        owner = rq.thread_id;
        depth = 0;
        st    = rlwq_pkg::STATUS_GRANTED;
      end else if (owner == rq.thread_id) begin
        if (depth >= MAX_DEPTH) begin
          st = rlwq_pkg::STATUS_SATURATED;
        end else begin
          depth++;
          st = rlwq_pkg::STATUS_NESTED_ACQ;
        end
      end else if (queued_map[rq.thread_id] || wait_line.size() >= rlwq_pkg::ID_SPACE) begin
        st = rlwq_pkg::STATUS_ALREADY_WAITING;
      end else begin
        wait_line.push_back(rq.thread_id);
        queued_map[rq.thread_id] = 1'b1;
        st = rlwq_pkg::STATUS_QUEUED;
      end
    end else begin
      if (!owned) begin
        st = rlwq_pkg::STATUS_NOT_HELD;
      end else if (depth > 0) begin
        depth--;
        st = rlwq_pkg::STATUS_NESTED_REL;
      end else if (wait_line.size() == 0) begin
        owned = 1'b0;
        owner = '0;
        st    = rlwq_pkg::STATUS_FREED;
      end else begin
        next             = wait_line.pop_front();
        queued_map[next] = 1'b0;
        owner            = next;
        depth            = 0;
        st               = rlwq_pkg::STATUS_HANDOFF;
      end
    end
    res.status        = st;
    res.new_holder    = owned ? owner : '0;
    res.held          = owned;
    res.waiting_count = rlwq_pkg::WCOUNT_W'(wait_line.size());
    return res;
  endfunction

  // Pick the next request for the current traffic mode, steered by lock state
  function automatic lock_req_t pick_request(traffic_mode_t mode);
    lock_req_t rq;
    int        roll;
    roll         = $urandom_range(0, 99);
    rq.thread_id = rlwq_pkg::THREAD_ID_W'($urandom_range(0, rlwq_pkg::ID_SPACE - 1));
    rq.req_type  = rlwq_pkg::REQ_ACQUIRE;
    case (mode)
      MODE_MIX: begin
        if (roll < 40) begin
          rq.req_type = rlwq_pkg::REQ_RELEASE;
        end else if (roll < 60 && owned) begin
          rq.thread_id = owner;
        end else if (roll < 80) begin
          rq.thread_id = rlwq_pkg::THREAD_ID_W'($urandom_range(0, 3));
        end
      end
      MODE_FILL: begin
        if (roll < 10) rq.req_type = rlwq_pkg::REQ_RELEASE;
      end
      MODE_DRAIN: begin
        if (roll < 85) rq.req_type = rlwq_pkg::REQ_RELEASE;
      end
      MODE_NEST: begin
        if (owned) begin
          if (roll < 4) rq.req_type = rlwq_pkg::REQ_RELEASE;
          else rq.thread_id = owner;
        end
      end
      default: begin
        rq.req_type = $urandom_range(0, 1) ? rlwq_pkg::REQ_RELEASE : rlwq_pkg::REQ_ACQUIRE;
      end
    endcase
    return rq;
  endfunction

  // Offer one word, honouring the burst pattern; predict once it is taken
  task automatic send_word(lock_req_t rq, bit fixed, lock_res_t fixed_res);
    lock_res_t predicted;
    int        gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= rq.req_type;
    in_ch.thread_id <= rq.thread_id;
    do @(posedge clk); while (!in_ch.ready);
    predicted = resolve_request(rq);
    expected_results.push_back(fixed ? fixed_res : predicted);
  endtask

  // Compare one taken result word with the oldest prediction
  task automatic check_result(lock_res_t got);
    lock_res_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("unexpected result word: status %0d holder %0d held %0d waiting %0d",
                 got.status, got.new_holder, got.held, got.waiting_count);
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status || got.new_holder !== want.new_holder ||
          got.held !== want.held || got.waiting_count !== want.waiting_count) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"result mismatch: expected status %0d holder %0d held %0d ",
                    "waiting %0d, got status %0d holder %0d held %0d waiting %0d"},
                   want.status, want.new_holder, want.held, want.waiting_count,
                   got.status, got.new_holder, got.held, got.waiting_count);
      end
    end
  endtask

  // Watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("recursive_lock_wait_queue_test: FAIL");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      check_result('{out_ch.status, out_ch.new_holder, out_ch.held, out_ch.waiting_count});
      results_taken++;
    end
  end

  // Result side: ready runs and stalls, plus one long hold-off mid-run
  initial begin
    bit held_off;
    held_off      = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held_off && results_taken >= HOLD_OFF_AT) begin
        held_off      = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Stimulus: directed script, then mode-driven random traffic
  initial begin
    traffic_mode_t mode;
    int            mode_left;
    int            sent;
    lock_req_t     rq;
    owned            = 1'b0;
    owner            = '0;
    depth            = 0;
    queued_map       = '0;
    mismatches       = 0;
    results_taken    = 0;
    burst_left       = 0;
    mode             = MODE_MIX;
    mode_left        = 0;
    sent             = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.req_type  <= rlwq_pkg::REQ_ACQUIRE;
    in_ch.thread_id <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed script
    foreach (lock_script[i]) begin
      for (int r = 0; r < lock_script[i].reps; r++) begin
        send_word('{lock_script[i].req_type, lock_script[i].thread_id},
                  lock_script[i].fixed, lock_script[i].res);
      end
    end

    // Random traffic in sequences of one mode each
    while (sent < RANDOM_WORDS) begin
      if (mode_left == 0) begin
        case ($urandom_range(0, 99)) inside
          [0:29]:  mode = MODE_MIX;
          [30:49]: mode = MODE_FILL;
          [50:64]: mode = MODE_DRAIN;
          [65:79]: mode = MODE_NEST;
          default: mode = MODE_NOISE;
        endcase
        mode_left = (mode == MODE_NEST) ? $urandom_range(20, 300) : $urandom_range(10, 80);
      end
      rq = pick_request(mode);
      send_word(rq, 1'b0, '0);
      mode_left--;
      sent++;
    end
    in_ch.valid <= 1'b0;

    // Drain outstanding results, then allow the pipeline to settle
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    mismatches += expected_results.size();
    if (mismatches == 0) begin
      $display("recursive_lock_wait_queue_test: PASS");
    end else begin
      $display("recursive_lock_wait_queue_test: FAIL");
    end
    $finish;
  end

endmodule : recursive_lock_wait_queue_test
